@@ hw/rtl/soa_pkg.sv @@
// ----------------------------------------------------------------------------
// Slab allocator package
// Shared types and constants for the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

  // Command codes carried on the request channel.
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_SHRINK = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOSLAB = 1'b1;

  // Field widths fixed by the interface.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SLAB_W  = 4;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned OPS_W   = 7;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_PICK    = 4'd1,
    OP_UNLINK  = 4'd2,
    OP_TAKE    = 4'd3,
    OP_FILE    = 4'd4,
    OP_FREEUPD = 4'd5,
    OP_SHSTEP  = 4'd6,
    OP_SHEND   = 4'd7,
    OP_LINKRD  = 4'd8
  } op_t;

  // Command from controller to datapath.
  typedef struct packed {
    op_t  op;
    logic clear_result;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic no_slab;
    logic free_ok;
    logic shrink_more;
  } dp_stat_t;

endpackage

@@ hw/rtl/soa_if.sv @@
// ----------------------------------------------------------------------------
// Slab allocator channels
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------
interface soa_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] slab_index;
  logic [5:0] slot_index;
  modport source (output valid, command, slab_index, slot_index, input ready);
  modport sink   (input valid, command, slab_index, slot_index, output ready);
endinterface

interface soa_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [3:0] given_slab;
  logic [5:0] given_slot;
  logic [4:0] slabs_released;
  modport source (output valid, status, given_slab, given_slot, slabs_released,
                  input ready);
  modport sink   (input valid, status, given_slab, given_slot, slabs_released,
                  output ready);
endinterface

interface soa_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/soa_datapath.sv @@
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Per-slab tables, list heads, the freed-slot link memory and the result.
// ----------------------------------------------------------------------------
module soa_datapath #(
  parameter int unsigned NUM_SLABS = 16,
  parameter int unsigned MAX_SLOTS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  soa_pkg::dp_cmd_t        cmd,
  output soa_pkg::dp_stat_t       stat,
  input  logic [1:0]              req_command,
  input  logic [3:0]              req_slab,
  input  logic [5:0]              req_slot,
  input  logic [6:0]              ops,
  output logic                    res_status,
  output logic [3:0]              res_slab,
  output logic [5:0]              res_slot,
  output logic [4:0]              res_released
);
  localparam int unsigned SW = $clog2(NUM_SLABS + 1);
  localparam int unsigned SI = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
  localparam int unsigned LW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned LI = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [SW-1:0] SNULL = SW'(NUM_SLABS);
  localparam logic [LW-1:0] LNULL = LW'(MAX_SLOTS);

  logic [NUM_SLABS-1:0] taken;
  logic [LW-1:0] free_slots [NUM_SLABS];
  logic [LW-1:0] ng_next    [NUM_SLABS];
  logic [LW-1:0] fhead      [NUM_SLABS];
  logic [SW-1:0] lnext      [NUM_SLABS];
  logic [SW-1:0] lprev      [NUM_SLABS];
  logic [LW-1:0] link_mem   [NUM_SLABS*MAX_SLOTS];
  logic [SW-1:0] empty_first, used_first, full_first;
  logic [SW-1:0] cur;
  logic          fresh;
  logic [LW-1:0] link_q;
  logic [1:0]    cmd_q;
  logic [5:0]    slot_q;
  logic [4:0]    rel_cnt;
  logic [SW:0]   walk;

  // Effective slots per slab, with out of range values clamped.
  logic [LW-1:0] n_eff;
  always_comb begin
    if (ops == 7'd0) n_eff = LW'(1);
    else if ({25'd0, ops} > 32'(MAX_SLOTS)) n_eff = LNULL;
    else n_eff = LW'(ops);
  end

  // Lowest slab not yet taken, by priority scan.
  logic [SW-1:0] low_free;
  always_comb begin
    low_free = SNULL;
    for (int i = NUM_SLABS - 1; i >= 0; i--) begin
      if (!taken[i]) low_free = SW'(i);
    end
  end

  logic [SI-1:0] ci;
  assign ci = cur[SI-1:0];
  logic [SI+LI-1:0] link_addr;
  logic [LI-1:0]    rslot;
  assign rslot = (cmd_q == soa_pkg::CMD_FREE) ? LI'(slot_q) : fhead[ci][LI-1:0];
  assign link_addr = {ci, rslot};

  logic free_valid;
  assign free_valid = ({28'd0, req_slab} < 32'(NUM_SLABS)) && taken[req_slab[SI-1:0]]
                      && ({26'd0, req_slot} < {25'd0, n_eff});

  assign stat.no_slab     = (cur == SNULL);
  assign stat.free_ok     = free_valid;
  assign stat.shrink_more = (empty_first != SNULL) && (walk < (SW+1)'(NUM_SLABS));

  // Link memory: one read and one write port, registered read.
  always_ff @(posedge clk) begin
    link_q <= link_mem[link_addr];
    if (cmd.op == soa_pkg::OP_FREEUPD)
      link_mem[link_addr] <= fhead[ci];
  end

  // Filing target list for the current slab after its fill is updated.
  function automatic logic [1:0] list_sel(input logic [LW-1:0] fs, input logic [LW-1:0] n);
    if (fs == '0) return 2'd2;
    else if (fs != n) return 2'd1;
    else return 2'd0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      taken      <= '0;
      empty_first <= SNULL;
      used_first  <= SNULL;
      full_first  <= SNULL;
      cur        <= SNULL;
      fresh      <= 1'b0;
      walk       <= '0;
      rel_cnt    <= '0;
      res_status <= 1'b0;
      res_slab   <= '0;
      res_slot   <= '0;
      res_released <= '0;
      cmd_q      <= soa_pkg::CMD_ALLOC;
      slot_q     <= '0;
    end else begin
      // A new request clears the result; an allocate with no slab anywhere fails here.
      if (cmd.clear_result) begin
        res_status <= (req_command == soa_pkg::CMD_ALLOC && used_first == SNULL &&
                       empty_first == SNULL && low_free == SNULL) ?
                      soa_pkg::STATUS_NOSLAB : soa_pkg::STATUS_OK;
        res_slab <= '0; res_slot <= '0; res_released <= '0;
        rel_cnt <= '0; walk <= '0;
      end
      case (cmd.op)
        // Choose the slab to serve an allocate, or the slab of a free.
        soa_pkg::OP_PICK: begin
          fresh <= 1'b0;
          cmd_q <= req_command;
          slot_q <= req_slot;
          if (req_command == soa_pkg::CMD_FREE) cur <= SW'(req_slab);
          else if (used_first != SNULL) cur <= used_first;
          else if (empty_first != SNULL) cur <= empty_first;
          else begin
            cur <= low_free;
            fresh <= (low_free != SNULL);
          end
        end
        // Take the slab off its list, or set up a freshly claimed slab.
        soa_pkg::OP_UNLINK: begin
          if (fresh) begin
            taken[ci] <= 1'b1;
            free_slots[ci] <= n_eff;
            ng_next[ci] <= '0;
            fhead[ci] <= LNULL;
            lnext[ci] <= SNULL;
            lprev[ci] <= SNULL;
          end else begin
            if (empty_first == cur) empty_first <= lnext[ci];
            else if (used_first == cur) used_first <= lnext[ci];
            else if (full_first == cur) full_first <= lnext[ci];
            if (lprev[ci] != SNULL) lnext[lprev[ci][SI-1:0]] <= lnext[ci];
            if (lnext[ci] != SNULL) lprev[lnext[ci][SI-1:0]] <= lprev[ci];
            lnext[ci] <= SNULL;
            lprev[ci] <= SNULL;
          end
        end
        // Link memory read address settles here.
        soa_pkg::OP_LINKRD: begin
        end
        // Hand out a slot.
        soa_pkg::OP_TAKE: begin
          if (fhead[ci] != LNULL) begin
            fhead[ci] <= link_q;
            if (free_slots[ci] != '0) free_slots[ci] <= free_slots[ci] - LW'(1);
            res_slab <= cur[3:0];
            res_slot <= fhead[ci][5:0];
          end else if (ng_next[ci] < n_eff) begin
            ng_next[ci] <= ng_next[ci] + LW'(1);
            if (free_slots[ci] != '0) free_slots[ci] <= free_slots[ci] - LW'(1);
            res_slab <= cur[3:0];
            res_slot <= ng_next[ci][5:0];
          end else begin
            res_status <= soa_pkg::STATUS_NOSLAB;
          end
        end
        // Push the freed slot onto its slab's stack.
        soa_pkg::OP_FREEUPD: begin
          if (free_slots[ci] < n_eff) free_slots[ci] <= free_slots[ci] + LW'(1);
          fhead[ci] <= LW'(slot_q);
        end
        // File the slab at the head of the list that matches its fill.
        soa_pkg::OP_FILE: begin
          lprev[ci] <= SNULL;
          case (list_sel(free_slots[ci], n_eff))
            2'd2: begin
              lnext[ci] <= full_first;
              if (full_first != SNULL) lprev[full_first[SI-1:0]] <= cur;
              full_first <= cur;
            end
            2'd1: begin
              lnext[ci] <= used_first;
              if (used_first != SNULL) lprev[used_first[SI-1:0]] <= cur;
              used_first <= cur;
            end
            default: begin
              lnext[ci] <= empty_first;
              if (empty_first != SNULL) lprev[empty_first[SI-1:0]] <= cur;
              empty_first <= cur;
            end
          endcase
        end
        // Return one empty slab to the pool.
        soa_pkg::OP_SHSTEP: begin
          empty_first <= lnext[empty_first[SI-1:0]];
          lnext[empty_first[SI-1:0]] <= SNULL;
          lprev[empty_first[SI-1:0]] <= SNULL;
          taken[empty_first[SI-1:0]] <= 1'b0;
          rel_cnt <= rel_cnt + 5'd1;
          walk <= walk + (SW+1)'(1);
        end
        soa_pkg::OP_SHEND: begin
          if (empty_first != SNULL) lprev[empty_first[SI-1:0]] <= SNULL;
          res_released <= rel_cnt;
        end
        soa_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // The head of the empty list never also heads the used or the full list.
  assert property (@(posedge clk) disable iff (rst)
    (empty_first != SNULL) |-> (empty_first != used_first && empty_first != full_first))
    else $error("slab on two lists");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == soa_pkg::OP_SHSTEP) |=> (rel_cnt == $past(rel_cnt) + 5'd1))
    else $error("shrink count slip");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == soa_pkg::OP_SHSTEP) |-> (empty_first != SNULL))
    else $error("shrink step on empty list");
endmodule

@@ hw/rtl/soa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Slab allocator controller
// Sequences the datapath operations of one request and the result beat.
// ----------------------------------------------------------------------------
module soa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        req_command,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output soa_pkg::dp_cmd_t  cmd,
  input  soa_pkg::dp_stat_t stat
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PICK   = 9'b000000010,
    S_UNLINK = 9'b000000100,
    S_LINKRD = 9'b000001000,
    S_TAKE   = 9'b000010000,
    S_FREE   = 9'b000100000,
    S_FILE   = 9'b001000000,
    S_SHRINK = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [1:0] op_cmd;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);

  // Latch the command of the accepted beat.
  always_ff @(posedge clk) begin
    if (rst) op_cmd <= soa_pkg::CMD_ALLOC;
    else if (req_valid && req_ready) op_cmd <= req_command;
  end

  // Next state and the command issued in each state.
  always_comb begin
    state_next = state;
    cmd.op = soa_pkg::OP_NONE;
    cmd.clear_result = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.clear_result = 1'b1;
          cmd.op = soa_pkg::OP_PICK;
          case (req_command)
            soa_pkg::CMD_ALLOC: state_next = S_PICK;
            soa_pkg::CMD_FREE:  state_next = stat.free_ok ? S_UNLINK : S_DONE;
            soa_pkg::CMD_SHRINK: state_next = S_SHRINK;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_PICK: state_next = stat.no_slab ? S_DONE : S_UNLINK;
      S_UNLINK: begin
        cmd.op = soa_pkg::OP_UNLINK;
        state_next = (op_cmd == soa_pkg::CMD_FREE) ? S_FREE : S_LINKRD;
      end
      S_LINKRD: begin
        cmd.op = soa_pkg::OP_LINKRD;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        cmd.op = soa_pkg::OP_TAKE;
        state_next = S_FILE;
      end
      S_FREE: begin
        cmd.op = soa_pkg::OP_FREEUPD;
        state_next = S_FILE;
      end
      S_FILE: begin
        cmd.op = soa_pkg::OP_FILE;
        state_next = S_DONE;
      end
      S_SHRINK: begin
        if (stat.shrink_more) cmd.op = soa_pkg::OP_SHSTEP;
        else begin
          cmd.op = soa_pkg::OP_SHEND;
          state_next = S_DONE;
        end
      end
      S_DONE: if (rsp_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_TAKE) |-> (op_cmd == soa_pkg::CMD_ALLOC)) else $error("take on non-alloc");
  assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid)) else $error("accept while result pending");
endmodule

@@ hw/rtl/slab_object_allocator.sv @@
// ----------------------------------------------------------------------------
// Slab object allocator
// Top level: request, result and configuration channels around the core.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate steps through slab choice,
// unlink, link memory read, slot take and refile before the result beat; a
// free through unlink, free update and refile; and a shrink returns one
// empty slab per step, bounded by NUM_SLABS. An allocate that finds no slab
// ends after the slab choice, and an ignored free or an unknown command goes
// straight to the result beat. The controller steps the shared list and link
// memory one update a cycle. The result is held until taken, and the next
// request is accepted in the cycle after.
module slab_object_allocator #(
  parameter int unsigned NUM_SLABS = 16,
  parameter int unsigned MAX_SLOTS = 64
) (
  input logic clk,
  input logic rst,
  soa_req_if.sink   req,
  soa_rsp_if.source rsp,
  soa_cfg_if.sink   cfg
);
  soa_pkg::dp_cmd_t  cmd;
  soa_pkg::dp_stat_t stat;
  logic [6:0] ops;

  // Configuration register, written whenever offered.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) ops <= 7'd64;
    else if (cfg.valid) ops <= cfg.data;
  end

  soa_ctrl u_ctrl (
    .clk, .rst,
    .req_valid(req.valid), .req_ready(req.ready), .req_command(req.command),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .cmd, .stat
  );

  soa_datapath #(.NUM_SLABS(NUM_SLABS), .MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .req_command(req.command), .req_slab(req.slab_index), .req_slot(req.slot_index),
    .ops,
    .res_status(rsp.status), .res_slab(rsp.given_slab), .res_slot(rsp.given_slot),
    .res_released(rsp.slabs_released)
  );
endmodule
